@@ hw/rtl/midi_track_event_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// MIDI track event parser: assertion macros
// Shared property forms for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define MTEP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtep: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtep: next-cycle check failed");

`endif

@@ hw/rtl/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Types, codes and helpers shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtep_pkg;

  localparam int VlqMaxBytes = 4;
  localparam int ValW        = 28;

  // Parser phases.
  localparam logic [2:0] PH_DELTA   = 3'd0;
  localparam logic [2:0] PH_STATUS  = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_MTYPE   = 3'd3;
  localparam logic [2:0] PH_MLEN    = 3'd4;
  localparam logic [2:0] PH_SXLEN   = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;

  // Byte roles.
  localparam logic [2:0] ROLE_DELTA   = 3'd0;
  localparam logic [2:0] ROLE_STATUS  = 3'd1;
  localparam logic [2:0] ROLE_DATA    = 3'd2;
  localparam logic [2:0] ROLE_MTYPE   = 3'd3;
  localparam logic [2:0] ROLE_LENGTH  = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
  localparam logic [2:0] ROLE_IGNORED = 3'd6;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NO_RUNNING = 2'd1;
  localparam logic [1:0] ERR_UNDEF_SYS  = 2'd2;
  localparam logic [1:0] ERR_VLQ_LONG   = 2'd3;

  // Status byte values.
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [3:0] NIB_SYSTEM   = 4'hF;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_PRESSURE = 4'hD;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       track_start;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]      byte_role;
    logic            event_done;
    logic [ValW-1:0] delta_ticks;
    logic [7:0]      event_status;
    logic [7:0]      meta_kind;
    logic            used_running;
    logic            track_ended;
    logic [1:0]      error_code;
  } out_beat_t;

  // Parser state apart from the VLQ byte count.
  typedef struct packed {
    logic [2:0]      phase;
    logic [ValW-1:0] delta_accum;
    logic [7:0]      running_cmd;
    logic [7:0]      current_cmd;
    logic [7:0]      meta_type_reg;
    logic [ValW-1:0] bytes_left;
    logic            ended_flag;
    logic            running_used;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_DELTA,
    delta_accum:   '0,
    running_cmd:   '0,
    current_cmd:   '0,
    meta_type_reg: '0,
    bytes_left:    '0,
    ended_flag:    1'b0,
    running_used:  1'b0
  };

  // Number of data bytes a channel status takes.
  function automatic logic [1:0] data_needed(input logic [7:0] st);
    logic [1:0] n;
    begin
      n = ((st[7:4] == NIB_PROGRAM) || (st[7:4] == NIB_PRESSURE)) ? 2'd1 : 2'd2;
      return n;
    end
  endfunction

endpackage

@@ hw/rtl/mtep_step.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser step
// Combinational parse of one track byte: next state and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_step #(
  parameter int VLQ_MAX_BYTES = mtep_pkg::VlqMaxBytes,
  parameter int CNT_W         = $clog2(VLQ_MAX_BYTES + 1)
) (
  input  mtep_pkg::state_t    cur,
  input  logic [CNT_W-1:0]    cnt,
  input  mtep_pkg::in_beat_t  item,
  output mtep_pkg::state_t    nxt,
  output logic [CNT_W-1:0]    cnt_next,
  output mtep_pkg::out_beat_t res
);

  localparam logic [CNT_W:0] CntLimit = (CNT_W + 1)'(VLQ_MAX_BYTES);

  always_comb begin
    mtep_pkg::state_t          base;
    logic [CNT_W-1:0]          base_cnt;
    logic [CNT_W:0]            cnt_inc;
    logic [mtep_pkg::ValW-1:0] vlq_src;
    logic [mtep_pkg::ValW-1:0] vlq_val;
    logic                      vlq_sat;
    logic                      vlq_end;
    logic [CNT_W-1:0]          vlq_cnt;
    logic [7:0]                b;
    logic [2:0]                role;
    logic                      done;
    logic                      ended;
    logic [1:0]                err;

    // A track start clears everything before the byte is parsed.
    base     = item.track_start ? mtep_pkg::STATE_RESET : cur;
    base_cnt = item.track_start ? '0 : cnt;
    b        = item.track_byte;
    nxt      = base;
    cnt_next = base_cnt;
    role     = mtep_pkg::ROLE_DELTA;
    done     = 1'b0;
    ended    = 1'b0;
    err      = mtep_pkg::ERR_NONE;
    res      = '0;

    // Shared VLQ accumulate for delta time and sysex length.
    cnt_inc = {1'b0, base_cnt} + (CNT_W + 1)'(1);
    if (base.phase == mtep_pkg::PH_DELTA) begin
      vlq_src = (base_cnt == '0) ? '0 : base.delta_accum;
    end else begin
      vlq_src = base.bytes_left;
    end
    vlq_sat = b[7] && (cnt_inc >= CntLimit);
    vlq_end = !b[7] || vlq_sat;
    vlq_val = vlq_sat ? '1 : {vlq_src[mtep_pkg::ValW-8:0], b[6:0]};
    vlq_cnt = vlq_end ? '0 : cnt_inc[CNT_W-1:0];

    if (base.ended_flag) begin
      res.byte_role = mtep_pkg::ROLE_IGNORED;
    end else begin
      unique case (base.phase)
        mtep_pkg::PH_DELTA: begin
          role = mtep_pkg::ROLE_DELTA;
          if (base_cnt == '0) begin
            nxt.current_cmd   = '0;
            nxt.meta_type_reg = '0;
            nxt.running_used  = 1'b0;
          end
          nxt.delta_accum = vlq_val;
          cnt_next        = vlq_cnt;
          if (vlq_sat) begin
            err = mtep_pkg::ERR_VLQ_LONG;
          end
          if (vlq_end) begin
            nxt.phase = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (b[7]) begin
            role            = mtep_pkg::ROLE_STATUS;
            nxt.current_cmd = b;
            if (b == mtep_pkg::ST_META) begin
              nxt.running_cmd = '0;
              nxt.phase       = mtep_pkg::PH_MTYPE;
            end else if ((b == mtep_pkg::ST_SYSEX) || (b == mtep_pkg::ST_SYSEX_ESC)) begin
              nxt.running_cmd = '0;
              nxt.bytes_left  = '0;
              cnt_next        = '0;
              nxt.phase       = mtep_pkg::PH_SXLEN;
            end else if (b[7:4] == mtep_pkg::NIB_SYSTEM) begin
              nxt.running_cmd = '0;
              err             = mtep_pkg::ERR_UNDEF_SYS;
              done            = 1'b1;
            end else begin
              nxt.running_cmd = b;
              nxt.bytes_left  = mtep_pkg::ValW'(mtep_pkg::data_needed(b));
              nxt.phase       = mtep_pkg::PH_DATA;
            end
          end else begin
            // Data byte in status position: running status or an error.
            role = mtep_pkg::ROLE_DATA;
            if (base.running_cmd == '0) begin
              err  = mtep_pkg::ERR_NO_RUNNING;
              done = 1'b1;
            end else begin
              nxt.current_cmd  = base.running_cmd;
              nxt.running_used = 1'b1;
              if (mtep_pkg::data_needed(base.running_cmd) == 2'd1) begin
                nxt.bytes_left = '0;
                done           = 1'b1;
              end else begin
                nxt.bytes_left = mtep_pkg::ValW'(1);
                nxt.phase      = mtep_pkg::PH_DATA;
              end
            end
          end
        end
        mtep_pkg::PH_DATA: begin
          role = mtep_pkg::ROLE_DATA;
          if (base.bytes_left != '0) begin
            nxt.bytes_left = base.bytes_left - mtep_pkg::ValW'(1);
          end
          done = (nxt.bytes_left == '0);
        end
        mtep_pkg::PH_MTYPE: begin
          role              = mtep_pkg::ROLE_MTYPE;
          nxt.meta_type_reg = b;
          nxt.phase         = mtep_pkg::PH_MLEN;
        end
        mtep_pkg::PH_MLEN: begin
          role           = mtep_pkg::ROLE_LENGTH;
          nxt.bytes_left = mtep_pkg::ValW'(b);
          if (b == '0) begin
            done = 1'b1;
          end else begin
            nxt.phase = mtep_pkg::PH_PAYLOAD;
          end
        end
        mtep_pkg::PH_SXLEN: begin
          role           = mtep_pkg::ROLE_LENGTH;
          nxt.bytes_left = vlq_val;
          cnt_next       = vlq_cnt;
          if (vlq_sat) begin
            err = mtep_pkg::ERR_VLQ_LONG;
          end
          if (vlq_end) begin
            if (vlq_val == '0) begin
              done = 1'b1;
            end else begin
              nxt.phase = mtep_pkg::PH_PAYLOAD;
            end
          end
        end
        default: begin
          role = mtep_pkg::ROLE_PAYLOAD;
          if (base.bytes_left != '0) begin
            nxt.bytes_left = base.bytes_left - mtep_pkg::ValW'(1);
          end
          done = (nxt.bytes_left == '0);
        end
      endcase

      // Event completion: check for end of track and go back to delta time.
      if (done) begin
        if ((nxt.current_cmd == mtep_pkg::ST_META) &&
            (nxt.meta_type_reg == mtep_pkg::META_EOT)) begin
          ended          = 1'b1;
          nxt.ended_flag = 1'b1;
        end
        nxt.phase = mtep_pkg::PH_DELTA;
        cnt_next  = '0;
      end

      res.byte_role    = role;
      res.event_done   = done;
      res.delta_ticks  = nxt.delta_accum;
      res.event_status = nxt.current_cmd;
      res.meta_kind    = (nxt.current_cmd == mtep_pkg::ST_META) ? nxt.meta_type_reg : '0;
      res.used_running = nxt.running_used;
      res.track_ended  = ended;
      res.error_code   = err;
    end
  end

endmodule

@@ hw/rtl/midi_track_event_parser_top.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser
// Classifies each byte of a Standard MIDI File track chunk by its role.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_data) takes one track byte
//   per beat; set track_start on the first byte of a new track to clear the
//   parser and running status. The result channel (result_valid,
//   result_stall, result_data) gives exactly one result beat per byte.
//   An accepted byte passes through the input register, then through the
//   parse logic feeding the result register, to its result on the port.
//   Throughput is one byte per cycle while the receiver does not stall, set
//   by the single parse step between those two registers.
//   When the receiver stalls, the result register holds its beat; the input
//   register still takes one more byte, then byte_stall rises until the
//   result is taken. Reset (rst, synchronous) empties both registers and
//   returns the parser to the delta-time phase with no running status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_track_event_parser_top_defines.svh"

module midi_track_event_parser_top #(
  parameter int VLQ_MAX_BYTES = mtep_pkg::VlqMaxBytes
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  mtep_pkg::in_beat_t  byte_data,
  output logic                result_valid,
  input  logic                result_stall,
  output mtep_pkg::out_beat_t result_data
);

  localparam int CNT_W = $clog2(VLQ_MAX_BYTES + 1);

  logic                in_full;
  mtep_pkg::in_beat_t  in_beat;
  mtep_pkg::state_t    state;
  mtep_pkg::state_t    state_next;
  logic [CNT_W-1:0]    vlq_count;
  logic [CNT_W-1:0]    vlq_count_next;
  mtep_pkg::out_beat_t res_next;
  logic                advance;
  logic                take;

  // The held byte moves on whenever the result register is free or draining.
  assign advance    = in_full && (!result_valid || !result_stall);
  assign byte_stall = in_full && !advance;
  assign take       = byte_valid && !byte_stall;

  mtep_step #(
    .VLQ_MAX_BYTES(VLQ_MAX_BYTES),
    .CNT_W        (CNT_W)
  ) u_step (
    .cur     (state),
    .cnt     (vlq_count),
    .item    (in_beat),
    .nxt     (state_next),
    .cnt_next(vlq_count_next),
    .res     (res_next)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= take || (in_full && !advance);
    end
    if (take) begin
      in_beat <= byte_data;
    end
  end

  // Parser state, updated once per parsed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtep_pkg::STATE_RESET;
      vlq_count <= '0;
    end else if (advance) begin
      state     <= state_next;
      vlq_count <= vlq_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result_data <= res_next;
    end
  end

  // End of track is only ever flagged on a completing byte.
  `MTEP_ASSERT_NOW(a_ended_done, clk, rst, result_valid && result_data.track_ended, result_data.event_done)
  // A completed event sends the parser back to delta time with a cleared count.
  `MTEP_ASSERT_NEXT(a_done_delta, clk, rst, advance && res_next.event_done, (state.phase == mtep_pkg::PH_DELTA) && (vlq_count == '0))
  // Once the track has ended, bytes without a track start are ignored.
  `MTEP_ASSERT_NEXT(a_ignore_after_end, clk, rst, advance && state.ended_flag && !in_beat.track_start, result_valid && (result_data.byte_role == mtep_pkg::ROLE_IGNORED))
  // The VLQ count stays below its limit between bytes.
  `MTEP_ASSERT_NOW(a_cnt_range, clk, rst, 1'b1, {1'b0, vlq_count} < (CNT_W + 1)'(VLQ_MAX_BYTES))

endmodule
